// ----- rtl/vlc_pkg.sv -----
package vlc_pkg;

    // Field widths
    localparam int STEER_W  = 12;
    localparam int THR_W    = 12;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 8;
    localparam int THRESH_W = 11;
    localparam int HOLD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Lamp timing and levels
    localparam int BLINK_PERIOD_MS = 800;
    localparam int BLINK_ON_MS     = 400;
    localparam int STOP_LEVEL      = 255;

    // Count trailing zero bits of a constant
    function automatic int ctz(input int v);
        int n;
        int done;
        n = 0;
        done = 0;
        for (int k = 0; k < 31; k++) begin
            if (done == 0 && ((v >> k) & 1) == 0) begin
                n = n + 1;
            end else begin
                done = 1;
            end
        end
        return n;
    endfunction

    // Blink phase: t mod P = t - P * floor(t / P), with the quotient taken from
    // (t >> BLINK_TZ) / BLINK_ODD through a reciprocal multiply.
    localparam int BLINK_TZ   = ctz(BLINK_PERIOD_MS);
    localparam int BLINK_ODD  = BLINK_PERIOD_MS >> BLINK_TZ;
    localparam int BLINK_XW   = TIME_W - BLINK_TZ;
    localparam int RECIP_SH   = BLINK_XW + $clog2(BLINK_ODD);
    localparam int RECIP_W    = BLINK_XW + 1;
    localparam int PROD_W     = BLINK_XW + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(BLINK_ODD) - 64'd1) / 64'(BLINK_ODD);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);

    // Indicator side codes
    typedef enum logic [1:0] {
        SIDE_OFF   = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TURN_ON_THRESH  = 3'd0,
        CFG_TURN_OFF_THRESH = 3'd1,
        CFG_TURN_MIN_MS     = 3'd2,
        CFG_BRAKE_DROP_US   = 3'd3,
        CFG_BRAKE_HOLD_MS   = 3'd4,
        CFG_DRL_WHEN_ARMED  = 3'd5,
        CFG_DRL_LEVEL       = 3'd6,
        CFG_TAIL_LEVEL      = 3'd7
    } t_cfg_reg;

    // Saturating deadline sum
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [HOLD_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W - HOLD_W + 1){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ----- rtl/vehicle_lamp_controller.sv -----
// Vehicle lamp controller.
// Input channel: one drive beat (steer, throttle_us, armed, time_ms) is taken at
// a rising edge with i_in_valid high and o_in_stall low. Output channel: one
// lamp beat per input beat, taken when o_out_valid is high and i_out_stall low.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at the
// clock edge; only write while no beat is in flight.
// Pipeline: three register stages (input register, stage 2, output register).
// Throughput: one beat per cycle while i_out_stall does not hold the output. The
// indicator and brake state is updated in the second stage from the input
// register, so each beat sees what the previous one left. The blink phase
// uses a reciprocal multiply on time_ms whose product is registered, then a
// multiply-subtract by the period in the output stage.
// Reset (synchronous, active low): all stages empty, indicator off, deadlines
// zero, throttle baseline unset, registers at their default values.
// Stall: when i_out_stall holds a presented beat, the output holds, the inner
// stages fill up, and o_in_stall rises once all three stages hold a beat.
module vehicle_lamp_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [vlc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vlc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // drive samples
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [vlc_pkg::STEER_W-1:0]  i_steer,
    input  logic [vlc_pkg::THR_W-1:0]           i_throttle_us,
    input  logic                                i_armed,
    input  logic [vlc_pkg::TIME_W-1:0]          i_time_ms,
    // lamp results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_left_lamps,
    output logic                                o_right_lamps,
    output logic [1:0]                          o_turn_side,
    output logic                                o_brake_active,
    output logic [vlc_pkg::LEVEL_W-1:0]         o_head_lamp,
    output logic [vlc_pkg::LEVEL_W-1:0]         o_red_level
);
    import vlc_pkg::*;

    // Configuration registers
    logic [THRESH_W-1:0] r_turn_on_thresh;
    logic [THRESH_W-1:0] r_turn_off_thresh;
    logic [HOLD_W-1:0]   r_turn_min_ms;
    logic [THR_W-1:0]    r_brake_drop_us;
    logic [HOLD_W-1:0]   r_brake_hold_ms;
    logic                r_drl_when_armed;
    logic [LEVEL_W-1:0]  r_drl_level;
    logic [LEVEL_W-1:0]  r_tail_level;

    // Controller state
    t_side               r_turn_state;
    logic [TIME_W-1:0]   r_turn_deadline;
    logic                r_seen_thr;
    logic [THR_W-1:0]    r_prev_thr;
    logic [TIME_W-1:0]   r_brake_deadline;

    // Stage 1: input register
    logic                      r_s1_valid;
    logic signed [STEER_W-1:0] r_s1_steer;
    logic [THR_W-1:0]          r_s1_thr;
    logic                      r_s1_armed;
    logic [TIME_W-1:0]         r_s1_time;

    // Stage 2: decided lamp state and blink quotient product
    logic                r_s2_valid;
    t_side               r_s2_side;
    logic                r_s2_brake;
    logic [LEVEL_W-1:0]  r_s2_head;
    logic [LEVEL_W-1:0]  r_s2_red;
    logic [PROD_W-1:0]   r_s2_prod;
    logic [TIME_W-1:0]   r_s2_time;

    // Stage 3: output register
    logic                r_out_valid;
    logic                r_out_left;
    logic                r_out_right;
    t_side               r_out_side;
    logic                r_out_brake;
    logic [LEVEL_W-1:0]  r_out_head;
    logic [LEVEL_W-1:0]  r_out_red;

    // Pipeline flow
    logic adv_out;
    logic adv_s2;
    logic in_take;
    assign adv_out = !r_out_valid || !i_out_stall;
    assign adv_s2  = !r_s2_valid || adv_out;
    assign o_in_stall = r_s1_valid && !adv_s2;
    assign in_take = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_on_thresh  <= THRESH_W'(512);
            r_turn_off_thresh <= THRESH_W'(256);
            r_turn_min_ms     <= HOLD_W'(1000);
            r_brake_drop_us   <= THR_W'(30);
            r_brake_hold_ms   <= HOLD_W'(500);
            r_drl_when_armed  <= 1'b1;
            r_drl_level       <= LEVEL_W'(128);
            r_tail_level      <= LEVEL_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TURN_ON_THRESH:  r_turn_on_thresh  <= i_cfg_data[THRESH_W-1:0];
                CFG_TURN_OFF_THRESH: r_turn_off_thresh <= i_cfg_data[THRESH_W-1:0];
                CFG_TURN_MIN_MS:     r_turn_min_ms     <= i_cfg_data[HOLD_W-1:0];
                CFG_BRAKE_DROP_US:   r_brake_drop_us   <= i_cfg_data[THR_W-1:0];
                CFG_BRAKE_HOLD_MS:   r_brake_hold_ms   <= i_cfg_data[HOLD_W-1:0];
                CFG_DRL_WHEN_ARMED:  r_drl_when_armed  <= i_cfg_data[0];
                CFG_DRL_LEVEL:       r_drl_level       <= i_cfg_data[LEVEL_W-1:0];
                CFG_TAIL_LEVEL:      r_tail_level      <= i_cfg_data[LEVEL_W-1:0];
            endcase
        end
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s2) begin
            r_s1_valid <= in_take;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_steer <= i_steer;
            r_s1_thr   <= i_throttle_us;
            r_s1_armed <= i_armed;
            r_s1_time  <= i_time_ms;
        end
    end

    // Indicator decision with hysteresis
    logic signed [STEER_W+1:0] steer_x;
    logic signed [STEER_W+1:0] on_x;
    logic [STEER_W-1:0]        mag;
    t_side                     want;
    t_side                     n_turn_state;
    logic [TIME_W-1:0]         n_turn_deadline;

    assign steer_x = $signed({{2{r_s1_steer[STEER_W-1]}}, r_s1_steer});
    assign on_x    = $signed({3'b000, r_turn_on_thresh});
    assign mag     = r_s1_steer[STEER_W-1] ? (~r_s1_steer + 1'b1) : r_s1_steer;

    always_comb begin
        priority if (steer_x <= -on_x) begin
            want = SIDE_LEFT;
        end else if (steer_x >= on_x) begin
            want = SIDE_RIGHT;
        end else begin
            want = SIDE_OFF;
        end
        n_turn_state    = r_turn_state;
        n_turn_deadline = r_turn_deadline;
        priority if (want != SIDE_OFF && want != r_turn_state) begin
            n_turn_state    = want;
            n_turn_deadline = sat_add(r_s1_time, r_turn_min_ms);
        end else if (r_turn_state != SIDE_OFF
                     && mag < {1'b0, r_turn_off_thresh}
                     && r_s1_time >= r_turn_deadline) begin
            n_turn_state = SIDE_OFF;
        end
    end

    // Brake trigger on a throttle drop
    logic [THR_W-1:0]        prev_eff;
    logic signed [THR_W:0]   drop;
    logic [TIME_W-1:0]       n_brake_deadline;
    logic                    brake_now;
    logic                    drl_now;
    logic [LEVEL_W-1:0]      red_now;

    assign prev_eff = r_seen_thr ? r_prev_thr : r_s1_thr;
    assign drop     = $signed({1'b0, prev_eff}) - $signed({1'b0, r_s1_thr});
    assign n_brake_deadline = (drop >= $signed({1'b0, r_brake_drop_us}))
                            ? sat_add(r_s1_time, r_brake_hold_ms) : r_brake_deadline;
    assign brake_now = r_s1_time < n_brake_deadline;
    assign drl_now   = r_drl_when_armed && r_s1_armed;

    always_comb begin
        priority if (brake_now) begin
            red_now = LEVEL_W'(STOP_LEVEL);
        end else if (drl_now) begin
            red_now = r_tail_level;
        end else begin
            red_now = '0;
        end
    end

    // Blink quotient: multiply by the reciprocal of the odd part of the period
    logic [PROD_W-1:0] blink_prod;
    assign blink_prod = PROD_W'(r_s1_time[TIME_W-1:BLINK_TZ]) * PROD_W'(RECIP_M);

    // State update and stage 2 register
    logic s1_move;
    assign s1_move = r_s1_valid && adv_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_state     <= SIDE_OFF;
            r_turn_deadline  <= '0;
            r_seen_thr       <= 1'b0;
            r_prev_thr       <= '0;
            r_brake_deadline <= '0;
        end else if (s1_move) begin
            r_turn_state     <= n_turn_state;
            r_turn_deadline  <= n_turn_deadline;
            r_seen_thr       <= 1'b1;
            r_prev_thr       <= r_s1_thr;
            r_brake_deadline <= n_brake_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_side  <= n_turn_state;
            r_s2_brake <= brake_now;
            r_s2_head  <= drl_now ? r_drl_level : '0;
            r_s2_red   <= red_now;
            r_s2_prod  <= blink_prod;
            r_s2_time  <= r_s1_time;
        end
    end

    // Blink phase: remainder of time against the period
    logic [TIME_W-1:0] blink_q;
    logic [TIME_W-1:0] blink_rem;
    logic              phase;
    assign blink_q   = TIME_W'(r_s2_prod >> RECIP_SH);
    assign blink_rem = r_s2_time - TIME_W'(blink_q * TIME_W'(BLINK_PERIOD_MS));
    assign phase     = blink_rem < TIME_W'(BLINK_ON_MS);

    // Output register
    logic s2_move;
    assign s2_move = r_s2_valid && adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_left  <= (r_s2_side == SIDE_LEFT) && phase;
            r_out_right <= (r_s2_side == SIDE_RIGHT) && phase;
            r_out_side  <= r_s2_side;
            r_out_brake <= r_s2_brake;
            r_out_head  <= r_s2_head;
            r_out_red   <= r_s2_red;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_lamps   = r_out_left;
    assign o_right_lamps  = r_out_right;
    assign o_turn_side    = r_out_side;
    assign o_brake_active = r_out_brake;
    assign o_head_lamp    = r_out_head;
    assign o_red_level    = r_out_red;

    // Input stalls only with every stage holding a beat and the output blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_out_valid && i_out_stall))
        else $error("input stalled with a free pipeline stage");

    // A new side always carries a deadline at or after its sample time
    a_side_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_turn_state != SIDE_OFF
         && r_turn_state != $past(r_turn_state))
        |-> (r_turn_deadline >= $past(r_s1_time)))
        else $error("indicator side changed without a valid hold deadline");

    // The indicator only drops once its hold deadline has passed
    a_side_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_turn_state == SIDE_OFF
         && $past(r_turn_state) != SIDE_OFF)
        |-> ($past(r_s1_time) >= $past(r_turn_deadline)))
        else $error("indicator released before its hold deadline");

    // A result appears only from a filled middle stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_s2_valid))
        else $error("result beat without a source beat");

endmodule
